FILE: hdl/ism_pkg.sv
package ism_pkg;

    localparam int VAL_W  = 31;
    localparam int MAG_W  = 30;
    localparam int Q_DEPTH = 4;
    localparam logic [MAG_W-1:0] MAG_RESET = 30'd1000000000;

    typedef enum logic [3:0] {
        OP_START  = 4'd0,
        OP_NUM    = 4'd1,
        OP_POP    = 4'd2,
        OP_INV    = 4'd3,
        OP_DUP    = 4'd4,
        OP_SWP    = 4'd5,
        OP_ADD    = 4'd6,
        OP_SUB    = 4'd7,
        OP_MUL    = 4'd8,
        OP_DIV    = 4'd9,
        OP_MOD    = 4'd10,
        OP_FINISH = 4'd11
    } t_op;

    typedef struct packed {
        t_op                      op;
        logic signed [VAL_W-1:0]  operand;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_front_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CHECK,
        S_DIV,
        S_FILL
    } t_state;

endpackage

FILE: hdl/integer_stack_machine.sv
// Integer stack machine: runs stack instructions on signed 31-bit values.
// Input channel: i_op / i_operand transfer when i_push is high and o_full
//   is low. A four-entry instruction queue sits in front of the executor,
//   so pushes continue while the executor is busy; unused op codes drop.
// Result channel: o_top_value / o_failed are valid while o_empty is low and
//   transfer when i_pop is high. Only a finish instruction makes a result.
// Config: i_cfg_we writes i_cfg_data into max_magnitude at once.
// Steps per instruction, after leaving the queue:
//   start, num, dup, inv, swp, finish: done in the idle state
//   pop: adds a refill state when the second entry must be refetched from stack RAM
//   add, sub, mul: register the result, then range check
//   div, mod: wait for the one-bit-a-cycle divider
// A finish taken by an idle executor writes the registered result slot.
// The top two stack entries live in registers; the rest sit in a RAM with
//   registered read, which is never cleared (only written entries are read).
// Reset clears the queue, the depth, the error flag and the result slot,
//   and sets max_magnitude to 1000000000.
// When the receiver stalls, a finish waits at the head of the queue until the result
//   slot is popped; the queue keeps filling until o_full rises.
module integer_stack_machine import ism_pkg::*; #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    output logic                     o_full,
    input  logic [3:0]               i_op,
    input  logic signed [VAL_W-1:0]  i_operand,
    input  logic                     i_pop,
    output logic                     o_empty,
    output logic signed [VAL_W-1:0]  o_top_value,
    output logic                     o_failed,
    input  logic                     i_cfg_we,
    input  logic [MAG_W-1:0]         i_cfg_data
);

    t_front_out       front_out;
    logic             take;
    logic [MAG_W-1:0] r_max_mag;

    // hold the magnitude limit; write it straight from the port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_mag <= MAG_RESET;
        end else if (i_cfg_we) begin
            r_max_mag <= i_cfg_data;
        end
    end

    ism_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_op     (i_op),
        .i_operand(i_operand),
        .o_full   (o_full),
        .o_out    (front_out),
        .i_take   (take)
    );

    ism_back #(.STACK_DEPTH(STACK_DEPTH)) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (front_out),
        .o_take     (take),
        .i_max_mag  (r_max_mag),
        .i_pop      (i_pop),
        .o_empty    (o_empty),
        .o_top_value(o_top_value),
        .o_failed   (o_failed)
    );

endmodule

FILE: hdl/ism_ram.sv
module ism_ram import ism_pkg::*; #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/ism_front.sv
module ism_front import ism_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [3:0]               i_op,
    input  logic signed [VAL_W-1:0]  i_operand,
    output logic                     o_full,
    output t_front_out               o_out,
    input  logic                     i_take
);

    localparam int QAW = $clog2(Q_DEPTH);

    t_item            r_mem [Q_DEPTH];
    logic [QAW-1:0]   r_wp, r_rp;
    logic [QAW:0]     r_cnt;
    logic             accept, enq, deq;

    assign o_full = (r_cnt == (QAW+1)'(Q_DEPTH));
    assign accept = i_push && !o_full;
    // drop unused op codes here: they change nothing
    assign enq    = accept && (i_op <= 4'(OP_FINISH));
    assign deq    = i_take && (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (enq) begin
                r_wp <= r_wp + 1'b1;
            end
            if (deq) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(enq) - (QAW+1)'(deq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (enq) begin
            r_mem[r_wp] <= '{op: t_op'(i_op), operand: i_operand};
        end
    end

    assign o_out.valid = (r_cnt != '0);
    assign o_out.item  = r_mem[r_rp];

endmodule

FILE: hdl/ism_div.sv
module ism_div import ism_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [VAL_W-1:0] i_dividend,
    input  logic [VAL_W-1:0] i_divisor,
    output logic             o_done,
    output logic [VAL_W-1:0] o_quot,
    output logic [VAL_W-1:0] o_rem
);

    logic [VAL_W-1:0] r_rem, r_quo, r_dvs;
    logic [4:0]       r_cnt;
    logic             r_busy, r_done;
    logic [VAL_W:0]   trial;
    logic             fits;

    assign trial = {r_rem, r_quo[VAL_W-1]};
    assign fits  = (trial >= {1'b0, r_dvs});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(VAL_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == 5'd1) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? VAL_W'(trial - {1'b0, r_dvs}) : trial[VAL_W-1:0];
            r_quo <= {r_quo[VAL_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

endmodule

FILE: hdl/ism_back.sv
module ism_back import ism_pkg::*; #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_front_out               i_in,
    output logic                     o_take,
    input  logic [MAG_W-1:0]         i_max_mag,
    input  logic                     i_pop,
    output logic                     o_empty,
    output logic signed [VAL_W-1:0]  o_top_value,
    output logic                     o_failed
);

    localparam int DW = $clog2(STACK_DEPTH + 1);
    localparam int AW = $clog2(STACK_DEPTH);
    localparam int PW = 2 * VAL_W;

    t_state                  r_state, n_state;
    logic signed [VAL_W-1:0] r_a, n_a, r_b, n_b;
    logic [DW-1:0]           r_depth, n_depth;
    logic                    r_err, n_err;
    logic signed [PW-1:0]    r_res, n_res;
    t_op                     r_op, n_op;
    logic                    r_out_v, n_out_v;
    logic signed [VAL_W-1:0] r_top, n_top;
    logic                    r_fail, n_fail;

    logic                    we;
    logic [AW-1:0]           waddr, raddr;
    logic [VAL_W-1:0]        rdata;
    logic                    div_start, div_done;
    logic [VAL_W-1:0]        div_q, div_r, mag_a, mag_b;
    logic [PW-1:0]           res_mag;
    logic [VAL_W-1:0]        div_val;
    logic                    full, has1, has2, has3;
    t_item                   it;

    ism_ram #(.WIDTH(VAL_W), .DEPTH(STACK_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(waddr),
        .i_wdata(r_b),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    assign mag_a = r_a[VAL_W-1] ? VAL_W'(-r_a) : VAL_W'(r_a);
    assign mag_b = r_b[VAL_W-1] ? VAL_W'(-r_b) : VAL_W'(r_b);

    ism_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (div_start),
        .i_dividend(mag_b),
        .i_divisor (mag_a),
        .o_done    (div_done),
        .o_quot    (div_q),
        .o_rem     (div_r)
    );

    assign it      = i_in.item;
    assign full    = (r_depth >= DW'(STACK_DEPTH));
    assign has1    = (r_depth >= DW'(1));
    assign has2    = (r_depth >= DW'(2));
    assign has3    = (r_depth >= DW'(3));
    assign waddr   = AW'(r_depth - DW'(2));
    assign raddr   = AW'(r_depth - DW'(3));
    assign res_mag = r_res[PW-1] ? PW'(-r_res) : PW'(r_res);

    always_comb begin
        if (r_op == OP_DIV) begin
            div_val = (r_a[VAL_W-1] ^ r_b[VAL_W-1]) ? VAL_W'(-div_q) : div_q;
        end else begin
            div_val = r_b[VAL_W-1] ? VAL_W'(-div_r) : div_r;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_depth <= '0;
            r_err   <= 1'b0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_depth <= n_depth;
            r_err   <= n_err;
            r_out_v <= n_out_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a   <= n_a;
        r_b   <= n_b;
        r_res <= n_res;
        r_op  <= n_op;
        r_top <= n_top;
        r_fail <= n_fail;
    end

    always_comb begin
        n_state   = r_state;
        n_a       = r_a;
        n_b       = r_b;
        n_depth   = r_depth;
        n_err     = r_err;
        n_res     = r_res;
        n_op      = r_op;
        n_out_v   = r_out_v && !i_pop;
        n_top     = r_top;
        n_fail    = r_fail;
        o_take    = 1'b0;
        we        = 1'b0;
        div_start = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in.valid && (it.op != OP_FINISH || !r_out_v)) begin
                    o_take = 1'b1;
                    n_op   = it.op;
                    if (it.op == OP_START) begin
                        n_depth = DW'(1);
                        n_a     = it.operand;
                        n_err   = 1'b0;
                    end else if (it.op == OP_FINISH) begin
                        n_out_v = 1'b1;
                        n_fail  = r_err || (r_depth != DW'(1));
                        n_top   = n_fail ? '0 : r_a;
                    end else if (!r_err) begin
                        case (it.op) inside
                            OP_NUM, OP_DUP: begin
                                if (full || (it.op == OP_DUP && !has1)) begin
                                    n_err = 1'b1;
                                end else begin
                                    we      = has2;
                                    n_b     = r_a;
                                    n_a     = (it.op == OP_NUM) ? it.operand : r_a;
                                    n_depth = r_depth + 1'b1;
                                end
                            end
                            OP_POP: begin
                                if (!has1) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_a     = r_b;
                                    n_depth = r_depth - 1'b1;
                                    if (has3) n_state = S_FILL;
                                end
                            end
                            OP_INV: begin
                                if (!has1) n_err = 1'b1;
                                else       n_a = VAL_W'(-r_a);
                            end
                            OP_SWP: begin
                                if (!has2) begin
                                    n_err = 1'b1;
                                end else begin
                                    n_a = r_b;
                                    n_b = r_a;
                                end
                            end
                            OP_ADD, OP_SUB, OP_MUL: begin
                                if (!has2) begin
                                    n_err = 1'b1;
                                end else begin
                                    if (it.op == OP_ADD)      n_res = PW'(r_b) + PW'(r_a);
                                    else if (it.op == OP_SUB) n_res = PW'(r_b) - PW'(r_a);
                                    else                      n_res = r_b * r_a;
                                    n_state = S_CHECK;
                                end
                            end
                            OP_DIV, OP_MOD: begin
                                if (!has2 || r_a == '0) begin
                                    n_err = 1'b1;
                                end else begin
                                    div_start = 1'b1;
                                    n_state   = S_DIV;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
            end
            S_CHECK: begin
                if (res_mag > PW'(i_max_mag)) begin
                    n_err   = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    n_a     = r_res[VAL_W-1:0];
                    n_depth = r_depth - 1'b1;
                    n_state = has3 ? S_FILL : S_IDLE;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_a     = div_val;
                    n_depth = r_depth - 1'b1;
                    n_state = has3 ? S_FILL : S_IDLE;
                end
            end
            S_FILL: begin
                n_b     = rdata;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_empty     = !r_out_v;
    assign o_top_value = r_top;
    assign o_failed    = r_fail;

endmodule

FILE: hdl/ism_checker.sv
module ism_checker import ism_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     i_pop,
    input logic                     o_empty,
    input logic                     o_full,
    input logic signed [VAL_W-1:0]  o_top_value,
    input logic                     o_failed
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> o_empty && !o_full)
        else $error("queues not empty after reset");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && o_failed |-> o_top_value == '0)
        else $error("failed result carries a value");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_top_value) && $stable(o_failed))
        else $error("stalled result changed");

endmodule

bind integer_stack_machine ism_checker u_ism_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_pop      (i_pop),
    .o_empty    (o_empty),
    .o_full     (o_full),
    .o_top_value(o_top_value),
    .o_failed   (o_failed)
);
